// ===== design/bid_pkg.sv =====
package bid_pkg;

  localparam int MAX_KNOTS  = 128;
  localparam int MAX_NODES  = 16;
  localparam int MAX_DEGREE = 7;

  localparam int KNOT_AW = $clog2(MAX_KNOTS);
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int COEF_AW = KNOT_AW + NODE_AW;
  localparam int WORK_AW = $clog2(MAX_DEGREE + 1);
  localparam int KC_W    = KNOT_AW + 1;

  // divider: 33-bit magnitude shifted up 16 -> 49 quotient bits
  localparam int DIV_STEPS = 49;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT = 1'd1;

  localparam logic [1:0] KIND_KNOT = 2'd0;
  localparam logic [1:0] KIND_COEF = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_WR_KNOT  = 5'd1;
  localparam logic [OP_W-1:0] OP_WR_COEF  = 5'd2;
  localparam logic [OP_W-1:0] OP_START    = 5'd3;
  localparam logic [OP_W-1:0] OP_RD_TLO   = 5'd4;
  localparam logic [OP_W-1:0] OP_RD_THI   = 5'd5;
  localparam logic [OP_W-1:0] OP_BS_INIT  = 5'd6;
  localparam logic [OP_W-1:0] OP_BS_RD    = 5'd7;
  localparam logic [OP_W-1:0] OP_BS_UPD   = 5'd8;
  localparam logic [OP_W-1:0] OP_MU_SET   = 5'd9;
  localparam logic [OP_W-1:0] OP_LD_RD    = 5'd10;
  localparam logic [OP_W-1:0] OP_LD_WR    = 5'd11;
  localparam logic [OP_W-1:0] OP_RED_INIT = 5'd12;
  localparam logic [OP_W-1:0] OP_T_RDJ    = 5'd13;
  localparam logic [OP_W-1:0] OP_T_CAPJ   = 5'd14;
  localparam logic [OP_W-1:0] OP_T_CAPK   = 5'd15;
  localparam logic [OP_W-1:0] OP_W_CAPL   = 5'd16;
  localparam logic [OP_W-1:0] OP_W_CAPH   = 5'd17;
  localparam logic [OP_W-1:0] OP_A_CAP    = 5'd18;
  localparam logic [OP_W-1:0] OP_BL_MUL   = 5'd19;
  localparam logic [OP_W-1:0] OP_BL_SUM   = 5'd20;
  localparam logic [OP_W-1:0] OP_F_RD0    = 5'd21;
  localparam logic [OP_W-1:0] OP_F_RD1    = 5'd22;
  localparam logic [OP_W-1:0] OP_F_DIV    = 5'd23;
  localparam logic [OP_W-1:0] OP_F_QP     = 5'd24;
  localparam logic [OP_W-1:0] OP_F_MUL    = 5'd25;
  localparam logic [OP_W-1:0] OP_F_OUT    = 5'd26;
  localparam logic [OP_W-1:0] OP_O_OUT    = 5'd27;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         node;
    logic [6:0]         slot;
    logic signed [31:0] value;
    logic signed [31:0] upstream_grad;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] grad_x;
    logic               out_of_range;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic kfew;
    logic oor_lo;
    logic oor_hi;
    logic bs_done;
    logic ld_last;
    logic p_one;
    logic j_last;
    logic k_last;
    logic div_busy;
    logic out_free;
  } sts_t;

  // {clipped, value}
  function automatic logic [32:0] sat32(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < -65'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // round to nearest, ties up, drop 16 fraction bits
  function automatic logic signed [64:0] round16(input logic signed [64:0] v);
    logic signed [64:0] w;
    w = v + 65'sd32768;
    return w >>> 16;
  endfunction

endpackage

// ===== design/bid_ram.sv =====
module bid_ram #(
  parameter int W = 32,
  parameter int D = 128
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bid_div.sv =====
// signed (num * 2^16) / den, truncated toward zero, saturated; one bit per cycle
module bid_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [32:0] den,
  output logic               busy,
  output logic signed [31:0] q,
  output logic               ovf
);

  logic                              busy_r, busy_nxt;
  logic [bid_pkg::DIV_CW-1:0]        cnt_r, cnt_nxt;
  logic [bid_pkg::DIV_STEPS-1:0]     dvd_r, dvd_nxt;
  logic [32:0]                       rem_r, rem_nxt;
  logic [32:0]                       dsr_r, dsr_nxt;
  logic                              neg_r, neg_nxt;
  logic [32:0]                       num_mag, den_mag;
  logic [33:0]                       sh;
  logic                              ge;

  assign num_mag = num[32] ? 33'(-num) : 33'(num);
  assign den_mag = den[32] ? 33'(-den) : 33'(den);
  assign sh = {rem_r, dvd_r[bid_pkg::DIV_STEPS-1]};
  assign ge = sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    if (start) begin
      rem_nxt = '0;
      dsr_nxt = den_mag;
      neg_nxt = num[32] ^ den[32];
      cnt_nxt = bid_pkg::DIV_CW'(bid_pkg::DIV_STEPS);
      if (den == 33'sd0) begin
        dvd_nxt  = '0;
        busy_nxt = 1'b0;
      end else begin
        dvd_nxt  = {num_mag, 16'h0000};
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? 33'(sh - {1'b0, dsr_r}) : sh[32:0];
      dvd_nxt = {dvd_r[bid_pkg::DIV_STEPS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == bid_pkg::DIV_CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    ovf = 1'b0;
    if (neg_r) begin
      if (dvd_r > bid_pkg::DIV_STEPS'(33'h080000000)) begin
        q   = 32'sh80000000;
        ovf = 1'b1;
      end else begin
        q = 32'(-dvd_r);
      end
    end else begin
      if (dvd_r > bid_pkg::DIV_STEPS'(33'h07fffffff)) begin
        q   = 32'sh7fffffff;
        ovf = 1'b1;
      end else begin
        q = 32'(dvd_r);
      end
    end
  end

  assign busy = busy_r;

endmodule

// ===== design/bid_dp.sv =====
module bid_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bid_pkg::cmd_t                  cmd,
  output bid_pkg::sts_t                  sts,
  input  bid_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [bid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bid_pkg::out_item_t             out_data
);

  localparam int KAW = bid_pkg::KNOT_AW;
  localparam int WAW = bid_pkg::WORK_AW;
  localparam int KCW = bid_pkg::KC_W;

  logic [2:0]          degree_r;
  logic [7:0]          knot_count_r;
  logic [2:0]          p_r;
  logic [KCW-1:0]      kc_r;
  logic [bid_pkg::NODE_AW-1:0] node_r;
  logic signed [31:0]  x_r, g_r, tj_r, dl_r, dh_r, a_r, qp_r;
  logic signed [63:0]  prod_r;
  logic [KAW-1:0]      lo_r, hi_r, m_r, mu_r, base_r, j_r;
  logic [2:0]          k_r;
  logic                sat_r;
  logic                out_valid_r;
  bid_pkg::out_item_t  out_r;

  logic [2:0]          p_eff;
  logic [KCW-1:0]      kc_eff;
  logic [31:0]         knot_rd_u, coef_rd_u, work_rd_u;
  logic signed [31:0]  knot_rd, coef_rd, work_rd;
  logic [KAW-1:0]      knot_raddr;
  logic [WAW-1:0]      work_raddr, work_waddr, l_idx;
  logic                work_we;
  logic [31:0]         work_wdata;
  logic [KAW-1:0]      m_calc, mu_calc, mu_hi;
  logic [KCW-1:0]      mu_hi_w;
  logic                div_start, div_busy, div_ovf;
  logic signed [32:0]  div_num, div_den;
  logic signed [31:0]  div_q;
  logic signed [32:0]  bl_diff;
  logic [32:0]         bl_diff_s;
  logic signed [63:0]  bl_prod;
  logic [32:0]         bl_sum_s, qp_s, res_s;
  logic signed [35:0]  qp_m;
  logic                out_free, out_load;
  bid_pkg::out_item_t  out_new;

  assign knot_rd = signed'(knot_rd_u);
  assign coef_rd = signed'(coef_rd_u);
  assign work_rd = signed'(work_rd_u);

  // clamp configuration
  always_comb begin
    if (degree_r == 3'd0) begin
      p_eff = 3'd1;
    end else if (4'(degree_r) > 4'(bid_pkg::MAX_DEGREE)) begin
      p_eff = 3'(bid_pkg::MAX_DEGREE);
    end else begin
      p_eff = degree_r;
    end
    if (9'(knot_count_r) > 9'(bid_pkg::MAX_KNOTS)) begin
      kc_eff = KCW'(bid_pkg::MAX_KNOTS);
    end else begin
      kc_eff = KCW'(knot_count_r);
    end
  end

  assign m_calc  = KAW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign mu_hi_w = kc_r - KCW'(p_r) - KCW'(2);
  assign mu_hi   = mu_hi_w[KAW-1:0];
  always_comb begin
    if (lo_r < KAW'(p_r)) begin
      mu_calc = KAW'(p_r);
    end else if (lo_r > mu_hi) begin
      mu_calc = mu_hi;
    end else begin
      mu_calc = lo_r;
    end
  end

  assign l_idx = WAW'(j_r - base_r);

  always_comb begin
    unique case (cmd.op)
      bid_pkg::OP_RD_TLO: knot_raddr = KAW'(p_r);
      bid_pkg::OP_RD_THI: knot_raddr = KAW'(kc_r - KCW'(p_r) - KCW'(1));
      bid_pkg::OP_BS_RD:  knot_raddr = m_calc;
      bid_pkg::OP_T_RDJ:  knot_raddr = j_r;
      bid_pkg::OP_T_CAPJ: knot_raddr = KAW'(j_r + KAW'(k_r));
      bid_pkg::OP_F_RD0:  knot_raddr = mu_r;
      bid_pkg::OP_F_RD1:  knot_raddr = KAW'(mu_r + KAW'(1));
      default:            knot_raddr = '0;
    endcase
    unique case (cmd.op)
      bid_pkg::OP_T_CAPK: work_raddr = WAW'(l_idx - WAW'(1));
      bid_pkg::OP_W_CAPL: work_raddr = l_idx;
      bid_pkg::OP_F_RD0:  work_raddr = WAW'(p_r - 3'd1);
      bid_pkg::OP_F_RD1:  work_raddr = WAW'(p_r);
      default:            work_raddr = '0;
    endcase
  end

  bid_ram #(.W(32), .D(bid_pkg::MAX_KNOTS)) u_knot_ram (
    .clk   (clk),
    .we    (cmd.op == bid_pkg::OP_WR_KNOT),
    .waddr (KAW'(in_data.slot)),
    .wdata (in_data.value),
    .raddr (knot_raddr),
    .rdata (knot_rd_u)
  );

  bid_ram #(.W(32), .D(bid_pkg::MAX_NODES * bid_pkg::MAX_KNOTS)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.op == bid_pkg::OP_WR_COEF),
    .waddr ({bid_pkg::NODE_AW'(in_data.node), KAW'(in_data.slot)}),
    .wdata (in_data.value),
    .raddr ({node_r, KAW'(base_r + j_r)}),
    .rdata (coef_rd_u)
  );

  // blend arithmetic
  assign bl_diff   = {dh_r[31], dh_r} - {dl_r[31], dl_r};
  assign bl_diff_s = bid_pkg::sat32({{32{bl_diff[32]}}, bl_diff});
  assign bl_prod   = a_r * signed'(bl_diff_s[31:0]);
  assign bl_sum_s  = bid_pkg::sat32({{33{dl_r[31]}}, dl_r}
                                    + bid_pkg::round16({prod_r[63], prod_r}));

  assign work_we    = (cmd.op == bid_pkg::OP_LD_WR) || (cmd.op == bid_pkg::OP_BL_SUM);
  assign work_waddr = (cmd.op == bid_pkg::OP_LD_WR) ? WAW'(j_r) : l_idx;
  assign work_wdata = (cmd.op == bid_pkg::OP_LD_WR) ? coef_rd : bl_sum_s[31:0];

  bid_ram #(.W(32), .D(bid_pkg::MAX_DEGREE + 1)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .raddr (work_raddr),
    .rdata (work_rd_u)
  );

  assign div_start = (cmd.op == bid_pkg::OP_T_CAPK) || (cmd.op == bid_pkg::OP_F_DIV);
  assign div_num   = (cmd.op == bid_pkg::OP_F_DIV) ?
                     ({work_rd[31], work_rd} - {dl_r[31], dl_r}) :
                     ({x_r[31], x_r} - {tj_r[31], tj_r});
  assign div_den   = {knot_rd[31], knot_rd} - {tj_r[31], tj_r};

  bid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .q     (div_q),
    .ovf   (div_ovf)
  );

  assign qp_m  = div_q * signed'({1'b0, p_r});
  assign qp_s  = bid_pkg::sat32({{29{qp_m[35]}}, qp_m});
  assign res_s = bid_pkg::sat32(bid_pkg::round16({prod_r[63], prod_r}));

  always_comb begin
    out_new = '0;
    if (cmd.op == bid_pkg::OP_O_OUT) begin
      out_new.out_of_range = 1'b1;
    end else begin
      out_new.grad_x    = signed'(res_s[31:0]);
      out_new.saturated = sat_r | res_s[32];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.op == bid_pkg::OP_F_OUT) || (cmd.op == bid_pkg::OP_O_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r     <= 3'd3;
      knot_count_r <= 8'd8;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == bid_pkg::CFG_DEGREE) begin
        degree_r <= cfg_data[2:0];
      end
      if (cfg_we && cfg_index == bid_pkg::CFG_KNOT_COUNT) begin
        knot_count_r <= cfg_data[7:0];
      end
      out_valid_r <= (out_valid_r && out_stall) || out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_new;
    end
    unique case (cmd.op)
      bid_pkg::OP_START: begin
        x_r    <= in_data.value;
        g_r    <= in_data.upstream_grad;
        node_r <= bid_pkg::NODE_AW'(in_data.node);
        p_r    <= p_eff;
        kc_r   <= kc_eff;
        sat_r  <= 1'b0;
      end
      bid_pkg::OP_BS_INIT: begin
        lo_r <= '0;
        hi_r <= KAW'(kc_r - KCW'(1));
      end
      bid_pkg::OP_BS_RD:  m_r <= m_calc;
      bid_pkg::OP_BS_UPD: begin
        if (knot_rd <= x_r) begin
          lo_r <= m_r;
        end else begin
          hi_r <= m_r;
        end
      end
      bid_pkg::OP_MU_SET: begin
        mu_r   <= mu_calc;
        base_r <= KAW'(mu_calc - KAW'(p_r));
        j_r    <= '0;
      end
      bid_pkg::OP_LD_WR: j_r <= KAW'(j_r + KAW'(1));
      bid_pkg::OP_RED_INIT: begin
        k_r <= p_r;
        j_r <= mu_r;
      end
      bid_pkg::OP_T_CAPJ: tj_r <= knot_rd;
      bid_pkg::OP_W_CAPL: dl_r <= work_rd;
      bid_pkg::OP_W_CAPH: dh_r <= work_rd;
      bid_pkg::OP_A_CAP: begin
        a_r   <= div_q;
        sat_r <= sat_r | div_ovf;
      end
      bid_pkg::OP_BL_MUL: begin
        prod_r <= bl_prod;
        sat_r  <= sat_r | bl_diff_s[32];
      end
      bid_pkg::OP_BL_SUM: begin
        sat_r <= sat_r | bl_sum_s[32];
        if (sts.j_last) begin
          k_r <= k_r - 3'd1;
          j_r <= mu_r;
        end else begin
          j_r <= KAW'(j_r - KAW'(1));
        end
      end
      bid_pkg::OP_F_RD1: begin
        dl_r <= work_rd;
        tj_r <= knot_rd;
      end
      bid_pkg::OP_F_QP: begin
        qp_r  <= signed'(qp_s[31:0]);
        sat_r <= sat_r | div_ovf | qp_s[32];
      end
      bid_pkg::OP_F_MUL: prod_r <= g_r * qp_r;
      default: ;
    endcase
  end

  always_comb begin
    sts.kfew     = kc_r < KCW'({1'b0, p_r, 1'b0}) + KCW'(2);
    sts.oor_lo   = x_r < knot_rd;
    sts.oor_hi   = x_r >= knot_rd;
    sts.bs_done  = KAW'(hi_r - lo_r) <= KAW'(1);
    sts.ld_last  = j_r == KAW'(p_r);
    sts.p_one    = p_r == 3'd1;
    sts.j_last   = j_r == KAW'(mu_r - KAW'(k_r) + KAW'(1));
    sts.k_last   = k_r == 3'd2;
    sts.div_busy = div_busy;
    sts.out_free = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/bid_ctrl.sv =====
module bid_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  logic [1:0]    in_kind,
  input  bid_pkg::sts_t sts,
  output bid_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK0 = 5'd1;
  localparam logic [4:0] S_CHK1 = 5'd2;
  localparam logic [4:0] S_CHK2 = 5'd3;
  localparam logic [4:0] S_BS0  = 5'd4;
  localparam logic [4:0] S_BS1  = 5'd5;
  localparam logic [4:0] S_LD0  = 5'd6;
  localparam logic [4:0] S_LD1  = 5'd7;
  localparam logic [4:0] S_RI   = 5'd8;
  localparam logic [4:0] S_R0   = 5'd9;
  localparam logic [4:0] S_R1   = 5'd10;
  localparam logic [4:0] S_R2   = 5'd11;
  localparam logic [4:0] S_R3   = 5'd12;
  localparam logic [4:0] S_R4   = 5'd13;
  localparam logic [4:0] S_R5   = 5'd14;
  localparam logic [4:0] S_R6   = 5'd15;
  localparam logic [4:0] S_R7   = 5'd16;
  localparam logic [4:0] S_F0   = 5'd17;
  localparam logic [4:0] S_F1   = 5'd18;
  localparam logic [4:0] S_F2   = 5'd19;
  localparam logic [4:0] S_F3   = 5'd20;
  localparam logic [4:0] S_F4   = 5'd21;
  localparam logic [4:0] S_F5   = 5'd22;
  localparam logic [4:0] S_OOR  = 5'd23;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = bid_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_kind)
            bid_pkg::KIND_KNOT: cmd.op = bid_pkg::OP_WR_KNOT;
            bid_pkg::KIND_COEF: cmd.op = bid_pkg::OP_WR_COEF;
            bid_pkg::KIND_EVAL: begin
              cmd.op    = bid_pkg::OP_START;
              state_nxt = S_CHK0;
            end
            default: ;
          endcase
        end
      end
      S_CHK0: begin
        cmd.op    = bid_pkg::OP_RD_TLO;
        state_nxt = sts.kfew ? S_OOR : S_CHK1;
      end
      S_CHK1: begin
        if (sts.oor_lo) begin
          state_nxt = S_OOR;
        end else begin
          cmd.op    = bid_pkg::OP_RD_THI;
          state_nxt = S_CHK2;
        end
      end
      S_CHK2: begin
        if (sts.oor_hi) begin
          state_nxt = S_OOR;
        end else begin
          cmd.op    = bid_pkg::OP_BS_INIT;
          state_nxt = S_BS0;
        end
      end
      S_BS0: begin
        if (sts.bs_done) begin
          cmd.op    = bid_pkg::OP_MU_SET;
          state_nxt = S_LD0;
        end else begin
          cmd.op    = bid_pkg::OP_BS_RD;
          state_nxt = S_BS1;
        end
      end
      S_BS1: begin
        cmd.op    = bid_pkg::OP_BS_UPD;
        state_nxt = S_BS0;
      end
      S_LD0: begin
        cmd.op    = bid_pkg::OP_LD_RD;
        state_nxt = S_LD1;
      end
      S_LD1: begin
        cmd.op    = bid_pkg::OP_LD_WR;
        state_nxt = sts.ld_last ? S_RI : S_LD0;
      end
      S_RI: begin
        cmd.op    = bid_pkg::OP_RED_INIT;
        state_nxt = sts.p_one ? S_F0 : S_R0;
      end
      S_R0: begin
        cmd.op    = bid_pkg::OP_T_RDJ;
        state_nxt = S_R1;
      end
      S_R1: begin
        cmd.op    = bid_pkg::OP_T_CAPJ;
        state_nxt = S_R2;
      end
      S_R2: begin
        cmd.op    = bid_pkg::OP_T_CAPK;
        state_nxt = S_R3;
      end
      S_R3: begin
        cmd.op    = bid_pkg::OP_W_CAPL;
        state_nxt = S_R4;
      end
      S_R4: begin
        cmd.op    = bid_pkg::OP_W_CAPH;
        state_nxt = S_R5;
      end
      S_R5: begin
        if (!sts.div_busy) begin
          cmd.op    = bid_pkg::OP_A_CAP;
          state_nxt = S_R6;
        end
      end
      S_R6: begin
        cmd.op    = bid_pkg::OP_BL_MUL;
        state_nxt = S_R7;
      end
      S_R7: begin
        cmd.op    = bid_pkg::OP_BL_SUM;
        state_nxt = (sts.j_last && sts.k_last) ? S_F0 : S_R0;
      end
      S_F0: begin
        cmd.op    = bid_pkg::OP_F_RD0;
        state_nxt = S_F1;
      end
      S_F1: begin
        cmd.op    = bid_pkg::OP_F_RD1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.op    = bid_pkg::OP_F_DIV;
        state_nxt = S_F3;
      end
      S_F3: begin
        if (!sts.div_busy) begin
          cmd.op    = bid_pkg::OP_F_QP;
          state_nxt = S_F4;
        end
      end
      S_F4: begin
        cmd.op    = bid_pkg::OP_F_MUL;
        state_nxt = S_F5;
      end
      S_F5: begin
        if (sts.out_free) begin
          cmd.op    = bid_pkg::OP_F_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_OOR: begin
        if (sts.out_free) begin
          cmd.op    = bid_pkg::OP_O_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== design/bspline_input_derivative.sv =====
// Input-gradient stage of a B-spline activation, Q16.16 fixed point.
// Knot loads (kind 0) and coefficient loads (kind 1) are written when accepted
// and give no result. A sample (kind 2) finds its knot interval by binary search,
// runs de Boor reduction down to degree 1 and returns
// g*p*(d[mu]-d[mu-1])/(t[mu+1]-t[mu]), saturated, with a flag for any clip.
// Samples outside [t[p], t[K-p-1]), or with K < 2p+2, give zero with
// out_of_range set once the range checks are done and the output is free.
// Per sample: range checks, binary search and the coefficient load, then a
// divider run for each of the p*(p+1)/2 - 1 reduction steps and one for the
// final slope. The radix-2 divider dominates; a result stall adds to it.
// The block takes one request at a time; a finished result sits in the output
// register while a new request enters.
// Degree 0 acts as 1, knot_count above 128 acts as 128. Config writes are
// taken any time but are meant only while the block is idle.
module bspline_input_derivative (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bid_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output bid_pkg::out_item_t            out_data,
  // register writes: 0 degree, 1 knot_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  bid_pkg::cmd_t cmd;
  bid_pkg::sts_t sts;
  logic          busy;
  logic          in_accept;

  // stall while a sample is in flight
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  bid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_kind   (in_data.kind),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  bid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/bid_chk.sv =====
module bid_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input bid_pkg::in_item_t             in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input bid_pkg::out_item_t            out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [bid_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                   cfg_data
);

  // result held under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // out-of-range result is zero and unclipped
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> out_data.grad_x == 32'sd0 && !out_data.saturated)
    else $error("out-of-range result not clean");

  // loads never hold off the next request
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind != bid_pkg::KIND_EVAL |=> !in_stall)
    else $error("load made the block busy");

  // an accepted sample raises the stall
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == bid_pkg::KIND_EVAL |=> in_stall)
    else $error("sample did not start");

endmodule

bind bspline_input_derivative bid_chk u_bid_chk (.*);

// ===== dv/bspline_input_derivative_checker.sv =====
`timescale 1ns / 1ps

module bspline_input_derivative_checker
  import bid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fails,
  output int                   waiting
);

  int          knot_mem [MAX_KNOTS];
  int          coef_mem [MAX_NODES*MAX_KNOTS];
  int          work [MAX_DEGREE+1];
  int unsigned deg_reg;
  int unsigned kc_reg;
  out_item_t   grad_queue [$];
  int          miss;

  function automatic int clip32(longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic int ratio16(longint num, longint den, inout bit hit);
    if (den == 0) return 0;
    return clip32((num * 65536) / den, hit);
  endfunction

  // gradient w.r.t. x for one sample
  function automatic out_item_t slope_grad(int unsigned node, longint x, longint g);
    int unsigned p, kc, lo, hi, m, mu, k, j, l, base;
    bit          hit;
    longint      diff, tj;
    int          a, qp, dl, res;
    out_item_t   r;
    p   = deg_reg;
    kc  = kc_reg;
    hit = 1'b0;
    if (p < 1) p = 1;
    if (p > MAX_DEGREE) p = MAX_DEGREE;
    if (kc > MAX_KNOTS) kc = MAX_KNOTS;
    if (node >= MAX_NODES || kc < 2 * p + 2 ||
        x < knot_mem[p] || x >= knot_mem[kc-p-1]) begin
      r.grad_x       = '0;
      r.out_of_range = 1'b1;
      r.saturated    = 1'b0;
      return r;
    end
    lo = 0;
    hi = kc - 1;
    while (hi - lo > 1) begin
      m = (lo + hi) / 2;
      if (knot_mem[m] <= x) lo = m;
      else hi = m;
    end
    mu = lo;
    if (mu < p) mu = p;
    if (mu > kc - p - 2) mu = kc - p - 2;
    base = mu - p;
    for (j = 0; j <= p; j++) work[j] = coef_mem[node*MAX_KNOTS + base + j];
    for (k = p; k > 1; k--) begin
      for (j = mu; j > mu - k; j--) begin
        l    = j - base;
        tj   = knot_mem[j];
        dl   = work[l-1];
        a    = ratio16(x - tj, longint'(knot_mem[j+k]) - tj, hit);
        diff = clip32(longint'(work[l]) - dl, hit);
        work[l] = clip32(dl + rnd16(longint'(a) * diff), hit);
      end
    end
    diff = longint'(work[p]) - work[p-1];
    a    = ratio16(diff, longint'(knot_mem[mu+1]) - knot_mem[mu], hit);
    qp   = clip32(longint'(a) * longint'(p), hit);
    res  = clip32(rnd16(g * qp), hit);
    r.grad_x       = res;
    r.out_of_range = 1'b0;
    r.saturated    = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      foreach (knot_mem[i]) knot_mem[i] = 0;
      foreach (coef_mem[i]) coef_mem[i] = 0;
      deg_reg = 3;
      kc_reg  = 8;
      grad_queue.delete();
      miss = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grad_queue.size() == 0) begin
          miss++;
          if (miss <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_item = grad_queue.pop_front();
          if (out_data !== exp_item) begin
            miss++;
            if (miss <= 10) $display("expected %p got %p", exp_item, out_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEGREE:     deg_reg = cfg_data[2:0];
          CFG_KNOT_COUNT: kc_reg  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_data.kind)
          KIND_KNOT: knot_mem[in_data.slot] = in_data.value;
          KIND_COEF: coef_mem[in_data.node*MAX_KNOTS + in_data.slot] = in_data.value;
          KIND_EVAL: grad_queue.push_back(slope_grad(in_data.node, in_data.value,
                                                     in_data.upstream_grad));
          default: ;
        endcase
      end
    end
    fails   <= miss;
    waiting <= grad_queue.size();
  end

endmodule

// ===== dv/tb_bspline_input_derivative.sv =====
`timescale 1ns / 1ps

module tb_bspline_input_derivative;
  import bid_pkg::*;

  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int     FULL_NODES  = 4;   // nodes 0..3 get complete coefficient rows

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int     fails;
  int     waiting;
  longint cycle = 0;
  bit     calm;
  int     tk [MAX_KNOTS];   // mirror of knots, used to aim samples into the span
  int     p_eff;
  int     kc_eff;

  // phase table: degree, knot_count, request count
  int ph_deg [9] = '{3, 1, 2, 7, 7, 0, 5, 4, 1};
  int ph_kc  [9] = '{8, 4, 16, 128, 8, 255, 40, 0, 128};
  int ph_n   [9] = '{200, 200, 200, 30, 20, 150, 60, 20, 200};

  bspline_input_derivative dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bspline_input_derivative_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .waiting   (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("bspline_input_derivative: mismatch");
      $finish;
    end
  end

  // periodic window where neither side idles
  assign calm = (cycle % 25000) < 4000;

  // result-side backpressure, changed on the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !calm && ($urandom_range(99) < 24);
    end
  end

  // mix of extremes, small fractions and raw random words
  function automatic int pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 0;
      3, 4, 5: return int'($urandom_range(0, 32'h3ffff)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // one request; valid stays up afterwards so back-to-back requests need no drop
  task automatic push(in_item_t it);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send(logic [1:0] kind, int node, int slot, int value, int g);
    in_item_t it;
    it.kind          = kind;
    it.node          = node[3:0];
    it.slot          = slot[6:0];
    it.value         = value;
    it.upstream_grad = g;
    push(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val, logic [31:0] keep);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = ($urandom & ~keep) | (val & keep);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain outstanding samples, then give the block time to go idle
  task automatic settle();
    in_valid = 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // rising knot vector over the knots in use; occasional zero step repeats a knot
  task automatic load_knots();
    int step_max;
    int t;
    case ($urandom_range(3))
      0:       step_max = 4;
      1:       step_max = 32'h100;
      2:       step_max = 32'h10000;
      default: step_max = 32'h7fffff;
    endcase
    t = int'($urandom_range(0, 32'h40000000)) - 32'h20000000;
    for (int i = 0; i < kc_eff; i++) begin
      tk[i] = t;
      send(KIND_KNOT, $urandom_range(15), i, t, $urandom);
      t += ($urandom_range(19) == 0) ? 0 : $urandom_range(1, step_max);
    end
  endtask

  // x inside [t[p], t[K-p-1]) when that span exists
  function automatic int span_x();
    longint lo, hi;
    if (kc_eff < 2 * p_eff + 2) return $urandom;
    lo = tk[p_eff];
    hi = tk[kc_eff-p_eff-1];
    if (hi <= lo) return int'(lo);
    return int'(lo + $urandom_range(0, int'(hi - lo - 1)));
  endfunction

  task automatic random_item();
    int r;
    int s;
    int x;
    r = $urandom_range(99);
    if (r < 55) begin
      case ($urandom_range(9))
        0:       x = $urandom;
        1:       x = (kc_eff > 0) ? tk[$urandom_range(0, kc_eff - 1)] : $urandom;
        default: x = span_x();
      endcase
      send(KIND_EVAL, $urandom_range(FULL_NODES - 1), $urandom, x, pick_value());
    end else if (r < 88) begin
      send(KIND_COEF, $urandom_range(15), $urandom_range(127), pick_value(), $urandom);
    end else if (r < 97) begin
      // knot rewrite: mostly same value, sometimes noise that unsorts the vector
      s = $urandom_range(127);
      if ($urandom_range(2) == 0) tk[s] = $urandom;
      send(KIND_KNOT, $urandom_range(15), s, tk[s], $urandom);
    end else begin
      send(2'd3, $urandom_range(15), $urandom_range(127), $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEGREE;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: degree 3, eight knots
    p_eff  = 3;
    kc_eff = 8;
    load_knots();
    for (int n = 0; n < FULL_NODES; n++)
      for (int s = 0; s < MAX_KNOTS; s++)
        send(KIND_COEF, n, s, pick_value(), $urandom);

    // directed: extreme coefficients, extreme gradients, span edges, ignored kind
    for (int s = 0; s < 5; s++)
      send(KIND_COEF, 1, s, (s % 2) ? 32'h80000000 : 32'h7fffffff, 0);
    send(KIND_EVAL, 1, 0, span_x(), 32'h7fffffff);
    send(KIND_EVAL, 1, 0, span_x(), 32'h80000000);
    send(KIND_EVAL, 1, 0, 32'h80000000, 32'h7fffffff);
    send(KIND_EVAL, 1, 0, 32'h7fffffff, 32'h7fffffff);
    send(KIND_EVAL, 1, 0, tk[3], 32'h00010000);     // lower span edge, inside
    send(KIND_EVAL, 1, 0, tk[4], 32'h00010000);     // upper span edge, outside
    send(KIND_EVAL, 15, 127, tk[4], 32'hffffffff);  // partial row, out of span
    send(2'd3, 15, 127, 32'hffffffff, 32'hffffffff);
    send(KIND_EVAL, 0, 0, span_x(), 0);

    // phases: each one reprograms both registers and reloads the knots
    for (int ph = 0; ph < 9; ph++) begin
      settle();
      write_reg(CFG_DEGREE, ph_deg[ph], 32'h7);
      write_reg(CFG_KNOT_COUNT, ph_kc[ph], 32'hff);
      p_eff  = (ph_deg[ph] == 0) ? 1 : ph_deg[ph];
      kc_eff = (ph_kc[ph] > MAX_KNOTS) ? MAX_KNOTS : ph_kc[ph];
      load_knots();
      repeat (ph_n[ph]) random_item();
    end

    settle();
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("bspline_input_derivative: match");
    end else begin
      $display("bspline_input_derivative: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bid_pkg.sv
design/bid_ram.sv
design/bid_div.sv
design/bid_dp.sv
design/bid_ctrl.sv
design/bspline_input_derivative.sv
design/bid_chk.sv
dv/bspline_input_derivative_checker.sv
dv/tb_bspline_input_derivative.sv
